FILE: hw/rtl/circular_list_engine_macros.svh
// Assertion shorthands for the circular list engine checkers.
// Both sample on the rising edge of clock and stay quiet while reset is high.
`ifndef CIRCULAR_LIST_ENGINE_MACROS_SVH
`define CIRCULAR_LIST_ENGINE_MACROS_SVH

// Same-cycle implication.
`define CLE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CLE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/cle_pkg.sv
package cle_pkg;

   localparam int DATA_BITS  = 32;
   localparam int COUNT_BITS = 7;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_FIRST     = 3'd2,
      OP_NEXT      = 3'd3,
      OP_REMOVE    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_NOCUR = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CUR_NONE  = 2'd0,
      CUR_FRESH = 2'd1,
      CUR_STALE = 2'd2
   } cursor_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_VALUE,
      S_LINK
   } fsm_type;

   typedef struct packed {
      op_type                       op;
      logic signed [DATA_BITS-1:0]  data_in;
   } req_type;

   typedef struct packed {
      status_type                   status;
      logic signed [DATA_BITS-1:0]  data_out;
      logic [COUNT_BITS-1:0]        count;
   } rsp_type;

   // Write enables of the node memories.
   typedef struct packed {
      logic value_we;
      logic link_we;
   } node_wr_type;

   // Free stack commands; never both in one cycle.
   typedef struct packed {
      logic pop;
      logic push;
   } free_ctl_type;

endpackage

FILE: hw/rtl/cle_node_mem.sv
module cle_node_mem #(
   parameter int POOL_NODES = 64,
   parameter int DATA_WIDTH = 32,
   localparam int IW = $clog2(POOL_NODES)
) (
   input  logic                   clock,
   input  cle_pkg::node_wr_type   wr,
   input  logic [IW-1:0]          link_raddr,
   output logic [IW-1:0]          link_rdata,
   input  logic [IW-1:0]          link_waddr,
   input  logic [IW-1:0]          link_wdata,
   input  logic [IW-1:0]          value_raddr,
   output logic [DATA_WIDTH-1:0]  value_rdata,
   input  logic [IW-1:0]          value_waddr,
   input  logic [DATA_WIDTH-1:0]  value_wdata
);

   logic [IW-1:0]         link_mem  [POOL_NODES];
   logic [DATA_WIDTH-1:0] value_mem [POOL_NODES];

   // Next pointers: one write, one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata <= link_mem[link_raddr];
   end

   // Stored values.
   always_ff @(posedge clock) begin
      if (wr.value_we) begin
         value_mem[value_waddr] <= value_wdata;
      end
      value_rdata <= value_mem[value_raddr];
   end

endmodule

FILE: hw/rtl/cle_free_stack.sv
module cle_free_stack #(
   parameter int POOL_NODES = 64,
   localparam int IW = $clog2(POOL_NODES),
   localparam int TW = $clog2(POOL_NODES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cle_pkg::free_ctl_type  ctl,
   input  logic [IW-1:0]          push_node,
   output logic [IW-1:0]          pop_node,
   output logic                   empty
);

   logic [IW-1:0] stack_mem [POOL_NODES];

   // top_ff counts free nodes; low_ff is the lowest top ever reached. Entries
   // below low_ff were never written; a pop from there returns the entry's own index.
   logic [TW-1:0] top_ff, top_in;
   logic [TW-1:0] low_ff, low_in;
   logic [IW-1:0] rd_ff;
   logic [IW-1:0] fresh_idx_ff;
   logic          fresh_ff;
   logic [IW-1:0] rd_addr;
   logic          push_ok;
   logic          pop_ok;

   assign empty   = (top_ff == '0);
   assign push_ok = ctl.push && (top_ff < TW'(POOL_NODES));
   assign pop_ok  = ctl.pop && !empty;
   assign rd_addr = empty ? '0 : IW'(top_ff - TW'(1));

   always_comb begin
      top_in = top_ff;
      low_in = low_ff;
      if (pop_ok) begin
         top_in = top_ff - TW'(1);
         if (top_ff == low_ff) begin
            low_in = top_ff - TW'(1);
         end
      end else if (push_ok) begin
         top_in = top_ff + TW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= TW'(POOL_NODES);
         low_ff <= TW'(POOL_NODES);
      end else begin
         top_ff <= top_in;
         low_ff <= low_in;
      end
   end

   // Read the top entry every cycle; bypass with its index if never written.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         stack_mem[top_ff[IW-1:0]] <= push_node;
      end
      rd_ff        <= stack_mem[rd_addr];
      fresh_ff     <= (top_ff == low_ff);
      fresh_idx_ff <= rd_addr;
   end

   assign pop_node = fresh_ff ? fresh_idx_ff : rd_ff;

endmodule

FILE: hw/rtl/circular_list_engine.sv
// Circular singly linked list engine. A request is taken when start is high
// and busy is low; each request gives exactly one response, shown on rsp_data
// for a single cycle with rsp_valid high. The receiver cannot stall, so it
// must take the response in that cycle. Nodes live in two synchronous RAMs
// (value and next pointer) plus a free-node stack RAM, each with a registered
// read. Busy stays high through S_EXEC alone for inserts into an empty list,
// remove, unknown ops and every error; through S_EXEC and S_LINK for inserts
// into a non-empty list (the second next-pointer write); and through S_EXEC
// and S_VALUE for first/next (the next-pointer read must land before the value
// read can be issued). The response appears in the cycle after the last busy
// cycle, and a new request may be started in that same cycle; a request is
// not taken while the previous one is still busy. There is no clearing
// pass after reset: the first request may be started in the cycle after
// reset falls.
module circular_list_engine #(
   parameter int POOL_NODES = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cle_pkg::req_type  req_data,
   output logic              rsp_valid,
   output cle_pkg::rsp_type  rsp_data
);

   localparam int IW = $clog2(POOL_NODES);
   localparam int CW = $clog2(POOL_NODES + 1);

   // Sequencer and list bookkeeping.
   cle_pkg::fsm_type    state_ff, state_in;
   cle_pkg::req_type    req_ff, req_in;
   cle_pkg::cursor_type cur_ff, cur_in;
   logic [IW-1:0]       link_addr_ff, link_addr_in;
   logic [IW-1:0]       node_ff, node_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic [IW-1:0]       cursor_ff, cursor_in;
   logic [IW-1:0]       prev_ff, prev_in;
   logic                nonempty_ff, nonempty_in;
   logic [CW-1:0]       count_ff, count_in;
   cle_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Memory ports.
   cle_pkg::node_wr_type  node_wr;
   cle_pkg::free_ctl_type free_ctl;
   logic [IW-1:0]         link_raddr, link_rdata, link_waddr, link_wdata;
   logic [IW-1:0]         value_raddr, value_waddr;
   logic [DATA_WIDTH-1:0] value_rdata, value_wdata;
   logic [IW-1:0]         free_node;
   logic                  free_empty;

   // Response assembly.
   logic                  resp_go;
   cle_pkg::status_type   resp_status;
   logic signed [31:0]    resp_data;
   logic signed [31:0]    value_sext;
   logic                  use_cursor;
   logic                  last_node;

   cle_node_mem #(
      .POOL_NODES (POOL_NODES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_node_mem (
      .clock       (clock),
      .wr          (node_wr),
      .link_raddr  (link_raddr),
      .link_rdata  (link_rdata),
      .link_waddr  (link_waddr),
      .link_wdata  (link_wdata),
      .value_raddr (value_raddr),
      .value_rdata (value_rdata),
      .value_waddr (value_waddr),
      .value_wdata (value_wdata)
   );

   cle_free_stack #(
      .POOL_NODES (POOL_NODES)
   ) u_free_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (free_ctl),
      .push_node (cursor_ff),
      .pop_node  (free_node),
      .empty     (free_empty)
   );

   // Stored values are the low DATA_WIDTH bits of the request, zero-filled
   // when wider; read back sign extended (or cut) to 32 bits.
   assign value_wdata = DATA_WIDTH'($unsigned(req_ff.data_in));
   assign value_sext  = 32'($signed(value_rdata));

   // Walk from the cursor for remove and for next with a live cursor;
   // everything else starts at the tail, whose link is the head.
   assign use_cursor = (req_data.op == cle_pkg::OP_REMOVE) ||
                       ((req_data.op == cle_pkg::OP_NEXT) && (cur_ff != cle_pkg::CUR_NONE));
   assign link_raddr = use_cursor ? cursor_ff : tail_ff;

   // In EXEC the value read chases the pointer just read; otherwise it
   // fetches the cursor node for remove.
   assign value_raddr = (state_ff == cle_pkg::S_EXEC) ? link_rdata : cursor_ff;
   assign value_waddr = free_node;

   assign last_node = (cursor_ff == tail_ff) && (link_rdata == cursor_ff);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      link_addr_in = link_addr_ff;
      node_in      = node_ff;
      tail_in      = tail_ff;
      cursor_in    = cursor_ff;
      prev_in      = prev_ff;
      nonempty_in  = nonempty_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      node_wr      = '0;
      free_ctl     = '0;
      link_waddr   = free_node;
      link_wdata   = free_node;
      resp_go      = 1'b0;
      resp_status  = cle_pkg::ST_OK;
      resp_data    = '0;

      case (state_ff)
         cle_pkg::S_IDLE: begin
            if (start) begin
               req_in       = req_data;
               link_addr_in = link_raddr;
               state_in     = cle_pkg::S_EXEC;
            end
         end

         cle_pkg::S_EXEC: begin
            case (req_ff.op)
               cle_pkg::OP_INS_FRONT, cle_pkg::OP_INS_BACK: begin
                  if (free_empty) begin
                     resp_go     = 1'b1;
                     resp_status = cle_pkg::ST_FULL;
                  end else begin
                     // New node links to the old head, or to itself if alone.
                     node_wr.value_we = 1'b1;
                     node_wr.link_we  = 1'b1;
                     link_waddr       = free_node;
                     link_wdata       = nonempty_ff ? link_rdata : free_node;
                     free_ctl.pop     = 1'b1;
                     node_in          = free_node;
                     count_in         = count_ff + CW'(1);
                     if (cur_ff == cle_pkg::CUR_FRESH) begin
                        cur_in = cle_pkg::CUR_STALE;
                     end
                     if (nonempty_ff) begin
                        state_in = cle_pkg::S_LINK;
                     end else begin
                        tail_in     = free_node;
                        nonempty_in = 1'b1;
                        resp_go     = 1'b1;
                     end
                  end
               end

               cle_pkg::OP_FIRST, cle_pkg::OP_NEXT: begin
                  if (!nonempty_ff) begin
                     resp_go     = 1'b1;
                     resp_status = cle_pkg::ST_EMPTY;
                  end else begin
                     prev_in   = link_addr_ff;
                     cursor_in = link_rdata;
                     cur_in    = cle_pkg::CUR_FRESH;
                     state_in  = cle_pkg::S_VALUE;
                  end
               end

               cle_pkg::OP_REMOVE: begin
                  resp_go = 1'b1;
                  if (!nonempty_ff) begin
                     resp_status = cle_pkg::ST_EMPTY;
                  end else if (cur_ff != cle_pkg::CUR_FRESH) begin
                     resp_status = cle_pkg::ST_NOCUR;
                  end else begin
                     // Unlink the cursor node and return it to the pool.
                     node_wr.link_we = 1'b1;
                     link_waddr      = prev_ff;
                     link_wdata      = link_rdata;
                     free_ctl.push   = 1'b1;
                     resp_data       = value_sext;
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                     end
                     if (last_node) begin
                        nonempty_in = 1'b0;
                        tail_in     = '0;
                        cursor_in   = '0;
                        prev_in     = '0;
                        cur_in      = cle_pkg::CUR_NONE;
                     end else begin
                        if (cursor_ff == tail_ff) begin
                           tail_in = prev_ff;
                        end
                        cursor_in = prev_ff;
                        cur_in    = cle_pkg::CUR_STALE;
                     end
                  end
               end

               default: begin
                  resp_go = 1'b1;
               end
            endcase
         end

         cle_pkg::S_VALUE: begin
            resp_go   = 1'b1;
            resp_data = value_sext;
         end

         cle_pkg::S_LINK: begin
            // Hook the new node in behind the tail.
            node_wr.link_we = 1'b1;
            link_waddr      = tail_ff;
            link_wdata      = node_ff;
            if (req_ff.op == cle_pkg::OP_INS_BACK) begin
               tail_in = node_ff;
            end
            resp_go = 1'b1;
         end

         default: begin
            state_in = cle_pkg::S_IDLE;
         end
      endcase

      if (resp_go) begin
         rsp_valid_in    = 1'b1;
         rsp_in.status   = resp_status;
         rsp_in.data_out = resp_data;
         rsp_in.count    = cle_pkg::COUNT_BITS'(count_in);
         state_in        = cle_pkg::S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cle_pkg::S_IDLE;
         cur_ff       <= cle_pkg::CUR_NONE;
         tail_ff      <= '0;
         cursor_ff    <= '0;
         prev_ff      <= '0;
         nonempty_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         prev_ff      <= prev_in;
         nonempty_ff  <= nonempty_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold the request, the walk address, the new node and the response.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      link_addr_ff <= link_addr_in;
      node_ff      <= node_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != cle_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/cle_checker.sv
`include "circular_list_engine_macros.svh"

module cle_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input cle_pkg::req_type  req_data,
   input logic              rsp_valid,
   input cle_pkg::rsp_type  rsp_data
);

   // Every accepted request leaves the engine busy.
   `CLE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request accepted but engine not busy")

   // A response only closes out work that was in progress.
   `CLE_ASSERT_IMP(a_rsp_after_busy, rsp_valid, $past(busy), "response without a busy cycle")

   // Responses never come back to back.
   `CLE_ASSERT_NXT(a_rsp_spaced, rsp_valid, !rsp_valid, "two responses in consecutive cycles")

   // An empty-list report leaves nothing counted and no data.
   `CLE_ASSERT_IMP(a_empty_zero, rsp_valid && (rsp_data.status == cle_pkg::ST_EMPTY), (rsp_data.count == '0) && (rsp_data.data_out == '0), "empty status with nonzero count or data")

   // Any failed request returns zero data.
   `CLE_ASSERT_IMP(a_err_no_data, rsp_valid && (rsp_data.status != cle_pkg::ST_OK), rsp_data.data_out == '0, "error response carries data")

endmodule

bind circular_list_engine cle_checker u_cle_checker (.*);
